// ----- rtl/lsel_pkg.sv -----
package lsel_pkg;

   localparam int CODE_W    = 16;
   localparam int SAMPLE_W  = 16;
   localparam int WRITES_W  = 32;
   localparam int DWELL_W   = 20;
   localparam int LEVEL_W   = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_START  = 2'd2,
      OP_FRAME  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_SONG   = 2'd1,
      CMD_RESUME = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_DWELL_FRAMES   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOUD_THRESHOLD = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRAFFIC_MARGIN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_LOCKED   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_REQUESTED_CODE = 3'd4;

   localparam logic [DWELL_W-1:0] DWELL_RESET     = 20'd22050;
   localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 16'd800;
   localparam logic [LEVEL_W-1:0] MARGIN_RESET    = 16'd800;
   localparam logic [CODE_W-1:0]  DEFAULT_CODE    = 16'd1;

   // Magnitude of a signed sample; the most negative value maps to 32768.
   function automatic logic [LEVEL_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
      logic [LEVEL_W-1:0] neg;
      neg = ~s + 1'b1;
      return s[SAMPLE_W-1] ? neg : s;
   endfunction

endpackage

// ----- rtl/lsel_ram.sv -----
module lsel_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/loudness_audition_selector.sv -----
// Each transaction is accepted in ST_IDLE, which issues the code list read,
// then moves to ST_EXEC, which evaluates the command and loads the result
// register once the result slot is free. No new request is taken in ST_EXEC,
// a split set by the registered code list read. A new request is taken while a result waits.
// Synchronous active-high reset restores the register defaults and empties the
// code list; list contents are not cleared.
module loudness_audition_selector #(
   parameter int LIST_DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // code_value[15:0], sample_left[31:16], sample_right[47:32], write_count[79:48]
   input  logic [lsel_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // song_code[15:0], command[17:16], is_locked[18], zero[23:19]
   output logic [lsel_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [lsel_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lsel_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import lsel_pkg::*;

   localparam int ADDR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int COUNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(LIST_DEPTH);

   state_type state_ff, state_in;

   logic [DWELL_W-1:0] dwell_frames_ff;
   logic [LEVEL_W-1:0] loud_threshold_ff;
   logic [LEVEL_W-1:0] traffic_margin_ff;
   logic               start_locked_ff;
   logic [CODE_W-1:0]  requested_code_ff;

   op_type              op_ff;
   logic [CODE_W-1:0]   code_ff;
   logic [SAMPLE_W-1:0] left_ff;
   logic [SAMPLE_W-1:0] right_ff;
   logic [WRITES_W-1:0] writes_ff;

   logic [COUNT_W-1:0]  list_count_ff, list_count_in;
   logic [COUNT_W-1:0]  next_index_ff, next_index_in;
   logic [CODE_W-1:0]   current_code_ff, current_code_in;
   logic [CODE_W-1:0]   best_code_ff, best_code_in;
   logic [LEVEL_W-1:0]  best_peak_ff, best_peak_in;
   logic [LEVEL_W-1:0]  window_peak_ff, window_peak_in;
   logic [DWELL_W-1:0]  dwell_left_ff, dwell_left_in;
   logic                locked_flag_ff, locked_flag_in;
   logic                extend_used_ff, extend_used_in;
   logic [WRITES_W-1:0] writes_at_window_ff, writes_at_window_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   cmd_type             rsp_cmd_ff, rsp_cmd_in;
   logic                rsp_locked_ff, rsp_locked_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [CODE_W-1:0]   ram_rdata;
   logic                read_start;

   logic                req_accept;
   logic                slot_free;
   logic [DWELL_W-1:0]  dwell_len;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign dwell_len  = (dwell_frames_ff == '0) ? DWELL_W'(1) : dwell_frames_ff;

   // The read address is held from the captured opcode while a transaction waits.
   assign read_start = (state_ff == ST_IDLE) ? (op_type'(req_tuser) == OP_START)
                                             : (op_ff == OP_START);
   assign ram_raddr  = read_start ? '0 : next_index_ff[ADDR_W-1:0];

   lsel_ram #(
      .WIDTH (CODE_W),
      .DEPTH (LIST_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_code_list (
      .clock(clock),
      .we   (ram_we),
      .waddr(list_count_ff[ADDR_W-1:0]),
      .wdata(code_ff),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_frames_ff   <= DWELL_RESET;
         loud_threshold_ff <= THRESHOLD_RESET;
         traffic_margin_ff <= MARGIN_RESET;
         start_locked_ff   <= 1'b0;
         requested_code_ff <= DEFAULT_CODE;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DWELL_FRAMES:   dwell_frames_ff   <= csr_wdata[DWELL_W-1:0];
            CSR_LOUD_THRESHOLD: loud_threshold_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_TRAFFIC_MARGIN: traffic_margin_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_START_LOCKED:   start_locked_ff   <= csr_wdata[0];
            CSR_REQUESTED_CODE: requested_code_ff <= csr_wdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= op_type'(req_tuser);
         code_ff   <= req_tdata[15:0];
         left_ff   <= req_tdata[31:16];
         right_ff  <= req_tdata[47:32];
         writes_ff <= req_tdata[79:48];
      end
      rsp_code_ff   <= rsp_code_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_locked_ff <= rsp_locked_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         list_count_ff       <= '0;
         next_index_ff       <= '0;
         current_code_ff     <= DEFAULT_CODE;
         best_code_ff        <= DEFAULT_CODE;
         best_peak_ff        <= '0;
         window_peak_ff      <= '0;
         dwell_left_ff       <= '0;
         locked_flag_ff      <= 1'b0;
         extend_used_ff      <= 1'b0;
         writes_at_window_ff <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         list_count_ff       <= list_count_in;
         next_index_ff       <= next_index_in;
         current_code_ff     <= current_code_in;
         best_code_ff        <= best_code_in;
         best_peak_ff        <= best_peak_in;
         window_peak_ff      <= window_peak_in;
         dwell_left_ff       <= dwell_left_in;
         locked_flag_ff      <= locked_flag_in;
         extend_used_ff      <= extend_used_in;
         writes_at_window_ff <= writes_at_window_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_comb begin
      logic [WRITES_W-1:0] rise;
      logic [LEVEL_W-1:0]  mag_l;
      logic [LEVEL_W-1:0]  mag_r;
      logic [LEVEL_W-1:0]  peak;
      logic                loud;
      cmd_type             cmd;

      state_in            = state_ff;
      list_count_in       = list_count_ff;
      next_index_in       = next_index_ff;
      current_code_in     = current_code_ff;
      best_code_in        = best_code_ff;
      best_peak_in        = best_peak_ff;
      window_peak_in      = window_peak_ff;
      dwell_left_in       = dwell_left_ff;
      locked_flag_in      = locked_flag_ff;
      extend_used_in      = extend_used_ff;
      writes_at_window_in = writes_at_window_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_tready;
      rsp_code_in         = rsp_code_ff;
      rsp_cmd_in          = rsp_cmd_ff;
      rsp_locked_in       = rsp_locked_ff;
      ram_we              = 1'b0;
      cmd                 = CMD_NONE;
      rise                = writes_ff - writes_at_window_ff;
      mag_l               = magnitude(left_ff);
      mag_r               = magnitude(right_ff);
      peak                = (mag_r > mag_l) ? mag_r : mag_l;
      loud                = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               case (op_ff)
                  OP_CLEAR: begin
                     list_count_in = '0;
                     next_index_in = '0;
                  end
                  OP_APPEND: begin
                     if (list_count_ff < DEPTH_C) begin
                        ram_we        = 1'b1;
                        list_count_in = list_count_ff + 1'b1;
                     end
                  end
                  OP_START: begin
                     current_code_in     = (list_count_ff != '0) ? ram_rdata : DEFAULT_CODE;
                     next_index_in       = COUNT_W'(1);
                     best_code_in        = (requested_code_ff != '0) ? requested_code_ff
                                                                     : DEFAULT_CODE;
                     best_peak_in        = '0;
                     window_peak_in      = '0;
                     dwell_left_in       = dwell_len;
                     extend_used_in      = 1'b0;
                     writes_at_window_in = writes_ff;
                     locked_flag_in      = start_locked_ff;
                     cmd                 = CMD_SONG;
                  end
                  OP_FRAME: begin
                     if (!locked_flag_ff) begin
                        if (dwell_left_ff == '0) begin
                           if (window_peak_ff > best_peak_ff) begin
                              best_peak_in = window_peak_ff;
                              best_code_in = current_code_ff;
                           end
                           window_peak_in = '0;
                           loud = best_peak_in > loud_threshold_ff;
                           if (!extend_used_ff && !loud &&
                               rise > {{(WRITES_W-LEVEL_W){1'b0}}, traffic_margin_ff}) begin
                              extend_used_in      = 1'b1;
                              dwell_left_in       = dwell_len;
                              writes_at_window_in = writes_ff;
                           end else if (loud) begin
                              locked_flag_in = 1'b1;
                              if (current_code_ff != best_code_in) begin
                                 current_code_in = best_code_in;
                                 cmd             = CMD_SONG;
                              end
                           end else if (next_index_ff < list_count_ff &&
                                        next_index_ff < DEPTH_C) begin
                              current_code_in     = ram_rdata;
                              next_index_in       = next_index_ff + 1'b1;
                              dwell_left_in       = dwell_len;
                              writes_at_window_in = writes_ff;
                              extend_used_in      = 1'b0;
                              cmd                 = CMD_RESUME;
                           end else begin
                              // The list is exhausted: settle on the loudest code seen.
                              locked_flag_in  = 1'b1;
                              current_code_in = (best_code_in != '0) ? best_code_in
                                                                     : DEFAULT_CODE;
                              cmd             = CMD_RESUME;
                           end
                        end else begin
                           dwell_left_in = dwell_left_ff - 1'b1;
                        end
                     end
                     if (!locked_flag_in && peak > window_peak_in) begin
                        window_peak_in = peak;
                     end
                  end
                  default: ;
               endcase
               rsp_code_in   = current_code_in;
               rsp_cmd_in    = cmd;
               rsp_locked_in = locked_flag_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_locked_ff, rsp_cmd_ff, rsp_code_ff};

   property p_count_bound;
      @(posedge clock) disable iff (reset) list_count_ff <= DEPTH_C;
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("code list count exceeds its depth");

   property p_accept_exec;
      @(posedge clock) disable iff (reset) req_accept |=> state_ff == ST_EXEC;
   endproperty
   a_accept_exec: assert property (p_accept_exec)
      else $error("accepted transaction did not enter execution");

   property p_exec_result;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_EXEC && slot_free) |=> rsp_valid_ff;
   endproperty
   a_exec_result: assert property (p_exec_result)
      else $error("executed transaction produced no result");

   property p_locked_frame;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_EXEC && op_ff == OP_FRAME && locked_flag_ff)
         |=> $stable(current_code_ff) && locked_flag_ff;
   endproperty
   a_locked_frame: assert property (p_locked_frame)
      else $error("locked selection changed on an audio frame");

endmodule
